// File: design/joypad_matrix_port_defines.svh
// Assertion macros shared by the joystick port. They assume a clock named clk
// and an active-low reset named arst_n in the module that uses them.
`ifndef JOYPAD_MATRIX_PORT_DEFINES_SVH
`define JOYPAD_MATRIX_PORT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JMP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("joystick port assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define JMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("joystick port assertion failed");

`endif

// File: design/jmp_pkg.sv
`default_nettype none

package jmp_pkg;

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	localparam logic [1:0] OFS_KEYS   = 2'd0;
	localparam logic [1:0] OFS_ROW_HI = 2'd1;
	localparam logic [1:0] OFS_FIRE   = 2'd2;

	localparam logic [15:0] RD_IDLE   = 16'hFFFF;
	localparam logic [15:0] FIRE_BASE = 16'hFF6F;
	localparam logic [15:0] NTSC_BIT  = 16'h0010;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_READ_KEYS,
		OP_READ_FIRE
	} op_t;

	typedef struct packed {
		logic [7:0] row_select;
		logic       pads_en;
		logic       audio_en;
		logic       ntsc;
	} port_state_t;

	typedef struct packed {
		op_t         op;
		port_state_t st;
		logic [15:0] pad0_keys;
		logic [4:0]  pad0_fire;
		logic [15:0] pad1_keys;
		logic [4:0]  pad1_fire;
	} req_entry_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] idx;
	} group_t;

endpackage

`default_nettype wire

// File: design/jmp_front.sv
`default_nettype none

module jmp_front import jmp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [1:0]  byte_offset,
	input  wire logic [15:0] write_data,
	input  wire logic [15:0] pad0_keys,
	input  wire logic [4:0]  pad0_fire,
	input  wire logic [15:0] pad1_keys,
	input  wire logic [4:0]  pad1_fire,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data,
	output logic             push,
	output req_entry_t       push_entry,
	input  wire logic        queue_ready,
	output port_state_t      state
);

	port_state_t st_q;
	port_state_t st_d;
	op_t         op;

	assign in_ready  = queue_ready;
	assign cfg_ready = 1'b1;
	assign push      = in_valid && queue_ready;
	assign state     = st_q;

	always_comb begin
		if (kind == KIND_WRITE) begin
			op = OP_NONE;
		end else begin
			unique case (byte_offset)
				OFS_KEYS: op = OP_READ_KEYS;
				OFS_FIRE: op = OP_READ_FIRE;
				default:  op = OP_NONE;
			endcase
		end
	end

	always_comb begin
		st_d = st_q;
		if (cfg_valid) begin
			st_d.ntsc = cfg_data;
		end
		if (push && kind == KIND_WRITE) begin
			if (byte_offset == OFS_KEYS) begin
				st_d.row_select = write_data[7:0];
				st_d.audio_en   = write_data[8];
				st_d.pads_en    = write_data[15];
			end else if (byte_offset == OFS_ROW_HI) begin
				st_d.row_select = write_data[15:8];
			end
		end
	end

	always_comb begin
		push_entry.op        = op;
		push_entry.st        = st_d;
		push_entry.pad0_keys = pad0_keys;
		push_entry.pad0_fire = pad0_fire;
		push_entry.pad1_keys = pad1_keys;
		push_entry.pad1_fire = pad1_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.row_select <= 8'h00;
			st_q.pads_en    <= 1'b0;
			st_q.audio_en   <= 1'b0;
			st_q.ntsc       <= 1'b1;
		end else begin
			st_q <= st_d;
		end
	end

endmodule

`default_nettype wire

// File: design/jmp_queue.sv
`default_nettype none

module jmp_queue import jmp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire req_entry_t push_entry,
	output logic            push_ready,
	output logic            head_valid,
	output req_entry_t      head_entry,
	input  wire logic       pop
);

	req_entry_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign push_ready = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push && push_ready) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && head_valid) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push && push_ready, pop && head_valid})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/jmp_back.sv
`default_nettype none

module jmp_back import jmp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire req_entry_t  head_entry,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      read_data,
	output logic             audio_on
);

	function automatic group_t pad0_group(input logic [3:0] nib);
		group_t g;
		g.hit = 1'b1;
		unique case (nib)
			4'hE:    g.idx = 2'd0;
			4'hD:    g.idx = 2'd1;
			4'hB:    g.idx = 2'd2;
			4'h7:    g.idx = 2'd3;
			default: begin
				g.hit = 1'b0;
				g.idx = 2'd0;
			end
		endcase
		return g;
	endfunction

	function automatic group_t pad1_group(input logic [3:0] nib);
		group_t g;
		g.hit = 1'b1;
		unique case (nib)
			4'h7:    g.idx = 2'd0;
			4'hB:    g.idx = 2'd1;
			4'hD:    g.idx = 2'd2;
			4'hE:    g.idx = 2'd3;
			default: begin
				g.hit = 1'b0;
				g.idx = 2'd0;
			end
		endcase
		return g;
	endfunction

	logic        out_valid_q;
	logic [15:0] read_data_q;
	logic        audio_q;
	group_t      g0;
	group_t      g1;
	logic [3:0]  nib0;
	logic [3:0]  nib1;
	logic [15:0] key_word;
	logic [15:0] fire_word;
	logic [15:0] word;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign audio_on  = audio_q;

	always_comb begin
		g0   = pad0_group(head_entry.st.row_select[3:0]);
		g1   = pad1_group(head_entry.st.row_select[7:4]);
		nib0 = 4'(head_entry.pad0_keys >> {g0.idx, 2'b00});
		nib1 = 4'(head_entry.pad1_keys >> {g1.idx, 2'b00});

		key_word = RD_IDLE;
		if (head_entry.st.pads_en) begin
			if (g0.hit) begin
				key_word[11:8] = ~nib0;
				if (g0.idx != 2'd0) begin
					key_word[{2'b00, g0.idx}] = 1'b0;
				end
			end
			if (g1.hit) begin
				key_word[15:12] = ~nib1;
				key_word[{1'b0, 3'd7 - {1'b0, g1.idx}}] = 1'b0;
			end
		end

		fire_word = head_entry.st.ntsc ? (FIRE_BASE | NTSC_BIT) : FIRE_BASE;
		if (head_entry.st.pads_en) begin
			if (g0.hit) begin
				if (head_entry.pad0_fire[g0.idx]) begin
					fire_word[1] = 1'b0;
				end
				if (g0.idx == 2'd0 && head_entry.pad0_fire[4]) begin
					fire_word[0] = 1'b0;
				end
			end
			if (g1.hit) begin
				if (head_entry.pad1_fire[g1.idx]) begin
					fire_word[3] = 1'b0;
				end
				if (g1.idx == 2'd0 && head_entry.pad1_fire[4]) begin
					fire_word[2] = 1'b0;
				end
			end
		end

		unique case (head_entry.op)
			OP_READ_KEYS: word = key_word;
			OP_READ_FIRE: word = fire_word;
			default:      word = RD_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			read_data_q <= word;
			audio_q     <= head_entry.st.audio_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: design/joypad_matrix_port.sv
// Two-pad matrix joystick port on a 16-bit bus.
// Requests arrive on the in_valid/in_ready channel: kind selects a read or a
// write, byte_offset the register, and the pad inputs are sampled with the
// request. Every request gives exactly one result on out_valid/out_ready:
// read_data (0xFFFF for writes and unmapped reads) and audio_on.
// The ntsc_machine flag is written on the cfg_valid/cfg_ready channel, which
// is always ready; write it only while no request is in flight.
// A front stage applies writes to the row-select and enable state at once
// and queues each request with a snapshot of that state; a back stage builds
// the read word from the queue head into the output register.
// Each accepted request is queued, then moved into the output register,
// setting out_valid. Throughput: one request per cycle while out_ready is high.
// When the receiver stalls, the output register holds its result and the
// two-entry queue absorbs up to two more requests before in_ready drops.
// Reset clears the row select and both enable flags, sets ntsc_machine to 1
// and empties the queue and the output register.
`default_nettype none
`include "joypad_matrix_port_defines.svh"

module joypad_matrix_port import jmp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic [1:0]  byte_offset,
	input  wire logic [15:0] write_data,
	input  wire logic [15:0] pad0_keys,
	input  wire logic [4:0]  pad0_fire,
	input  wire logic [15:0] pad1_keys,
	input  wire logic [4:0]  pad1_fire,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      read_data,
	output logic             audio_on,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);

	logic        push;
	req_entry_t  push_entry;
	logic        queue_ready;
	logic        head_valid;
	req_entry_t  head_entry;
	logic        pop;
	port_state_t state;

	jmp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.byte_offset (byte_offset),
		.write_data  (write_data),
		.pad0_keys   (pad0_keys),
		.pad0_fire   (pad0_fire),
		.pad1_keys   (pad1_keys),
		.pad1_fire   (pad1_fire),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.push        (push),
		.push_entry  (push_entry),
		.queue_ready (queue_ready),
		.state       (state)
	);

	jmp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.push_ready (queue_ready),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	jmp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.audio_on   (audio_on)
	);

	`JMP_ASSERT_NEXT(a_ctrl_write, push && kind == KIND_WRITE && byte_offset == OFS_KEYS, state.row_select == $past(write_data[7:0]) && state.audio_en == $past(write_data[8]) && state.pads_en == $past(write_data[15]))
	`JMP_ASSERT_NEXT(a_row_write, push && kind == KIND_WRITE && byte_offset == OFS_ROW_HI, state.row_select == $past(write_data[15:8]))
	`JMP_ASSERT_NEXT(a_none_idle, pop && head_entry.op == OP_NONE, out_valid && read_data == RD_IDLE)
	`JMP_ASSERT_NOW(a_pop_valid, pop, head_valid)

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import jmp_pkg::*;

	localparam logic [1:0] OFS_SPARE = 2'd3;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic        kind;
		logic [1:0]  ofs;
		logic [15:0] wdata;
		logic [15:0] k0;
		logic [4:0]  f0;
		logic [15:0] k1;
		logic [4:0]  f1;
	} bus_access_t;

	typedef struct {
		logic [15:0] data;
		logic        audio;
	} port_reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = KIND_READ;
	logic [1:0]  byte_offset = OFS_KEYS;
	logic [15:0] write_data = 16'h0000;
	logic [15:0] pad0_keys = 16'h0000;
	logic [4:0]  pad0_fire = 5'h00;
	logic [15:0] pad1_keys = 16'h0000;
	logic [4:0]  pad1_fire = 5'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] read_data;
	logic        audio_on;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;

	bus_access_t access_backlog[$];
	port_reply_t awaited_replies[$];
	bus_access_t offered;
	port_reply_t want;

	logic [7:0] row_sel = 8'h00;
	logic       pads_on = 1'b0;
	logic       audio_flag = 1'b0;
	logic       ntsc_flag = 1'b1;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int replies_seen = 0;
	int hold_left = 0;
	int errors = 0;

	joypad_matrix_port uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.byte_offset(byte_offset),
		.write_data (write_data),
		.pad0_keys  (pad0_keys),
		.pad0_fire  (pad0_fire),
		.pad1_keys  (pad1_keys),
		.pad1_fire  (pad1_fire),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_data  (read_data),
		.audio_on   (audio_on),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic group_t pad0_group(logic [3:0] nib);
		group_t g;
		g.hit = 1'b1;
		case (nib)
			4'hE: g.idx = 2'd0;
			4'hD: g.idx = 2'd1;
			4'hB: g.idx = 2'd2;
			4'h7: g.idx = 2'd3;
			default: begin
				g.hit = 1'b0;
				g.idx = 2'd0;
			end
		endcase
		return g;
	endfunction

	function automatic group_t pad1_group(logic [3:0] nib);
		group_t g;
		g.hit = 1'b1;
		case (nib)
			4'h7: g.idx = 2'd0;
			4'hB: g.idx = 2'd1;
			4'hD: g.idx = 2'd2;
			4'hE: g.idx = 2'd3;
			default: begin
				g.hit = 1'b0;
				g.idx = 2'd0;
			end
		endcase
		return g;
	endfunction

	// Applies one request to the port state and returns the word it reads back.
	function automatic port_reply_t bus_reply(bus_access_t a);
		port_reply_t r;
		group_t g0;
		group_t g1;
		r.data = RD_IDLE;
		g0 = pad0_group(row_sel[3:0]);
		g1 = pad1_group(row_sel[7:4]);
		if (a.kind == KIND_WRITE) begin
			if (a.ofs == OFS_KEYS) begin
				row_sel = a.wdata[7:0];
				audio_flag = a.wdata[8];
				pads_on = a.wdata[15];
			end else if (a.ofs == OFS_ROW_HI) begin
				row_sel = a.wdata[15:8];
			end
		end else if (a.ofs == OFS_KEYS) begin
			if (pads_on) begin
				if (g0.hit) begin
					for (int i = 0; i < 4; i++)
						if (a.k0[4 * g0.idx + i])
							r.data[8 + i] = 1'b0;
					if (g0.idx != 2'd0)
						r.data[g0.idx] = 1'b0;
				end
				if (g1.hit) begin
					for (int i = 0; i < 4; i++)
						if (a.k1[4 * g1.idx + i])
							r.data[12 + i] = 1'b0;
					r.data[7 - g1.idx] = 1'b0;
				end
			end
		end else if (a.ofs == OFS_FIRE) begin
			r.data = FIRE_BASE | (ntsc_flag ? NTSC_BIT : 16'h0000);
			if (pads_on) begin
				if (g0.hit) begin
					if (a.f0[g0.idx])
						r.data[1] = 1'b0;
					if (g0.idx == 2'd0 && a.f0[4])
						r.data[0] = 1'b0;
				end
				if (g1.hit) begin
					if (a.f1[g1.idx])
						r.data[3] = 1'b0;
					if (g1.idx == 2'd0 && a.f1[4])
						r.data[2] = 1'b0;
				end
			end
		end
		r.audio = audio_flag;
		return r;
	endfunction

	function automatic bus_access_t mk_access(logic k, logic [1:0] o, logic [15:0] wd,
			logic [15:0] k0, logic [4:0] f0, logic [15:0] k1, logic [4:0] f1);
		bus_access_t a;
		a.kind = k;
		a.ofs = o;
		a.wdata = wd;
		a.k0 = k0;
		a.f0 = f0;
		a.k1 = k1;
		a.f1 = f1;
		return a;
	endfunction

	function automatic logic [3:0] row_nibble();
		logic [3:0] nib;
		case ($urandom_range(3))
			0: nib = 4'hE;
			1: nib = 4'hD;
			2: nib = 4'hB;
			default: nib = 4'h7;
		endcase
		if ($urandom_range(99) < 15)
			nib = 4'($urandom_range(15));
		return nib;
	endfunction

	// Mostly key and fire reads, some row-select writes, with some noise.
	function automatic bus_access_t random_access();
		bus_access_t a;
		int pick;
		a = mk_access(KIND_READ, OFS_KEYS, 16'($urandom), 16'($urandom),
			5'($urandom_range(31)), 16'($urandom), 5'($urandom_range(31)));
		pick = $urandom_range(99);
		if (pick < 25) begin
			a.kind = KIND_WRITE;
			if ($urandom_range(3) == 0) begin
				a.ofs = OFS_ROW_HI;
				a.wdata[15:8] = {row_nibble(), row_nibble()};
			end else begin
				a.ofs = OFS_KEYS;
				a.wdata[7:0] = {row_nibble(), row_nibble()};
				a.wdata[15] = ($urandom_range(99) < 85);
			end
		end else if (pick < 32) begin
			a.kind = 1'($urandom_range(1));
			a.ofs = 2'($urandom_range(3));
		end else begin
			a.ofs = $urandom_range(1) ? OFS_FIRE : OFS_KEYS;
		end
		return a;
	endfunction

	task automatic write_ntsc(input logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		ntsc_flag = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		while (access_backlog.size() != 0 || in_valid || awaited_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				awaited_replies.push_back(bus_reply(offered));
			if (!in_valid || in_ready) begin
				if (access_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered = access_backlog.pop_front();
					in_valid <= 1'b1;
					kind <= offered.kind;
					byte_offset <= offered.ofs;
					write_data <= offered.wdata;
					pad0_keys <= offered.k0;
					pad0_fire <= offered.f0;
					pad1_keys <= offered.k1;
					pad1_fire <= offered.f1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The receiver stops taking results for a long stretch twice so that the
	// port fills up and drops in_ready.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				replies_seen++;
				if (replies_seen == 200 || replies_seen == 1000)
					hold_left = HOLD_CYCLES;
				if (awaited_replies.size() == 0) begin
					$display("%0t: expected no result, got read_data %h audio_on %b", $time,
						read_data, audio_on);
					errors++;
				end else begin
					want = awaited_replies.pop_front();
					if (read_data !== want.data) begin
						$display("%0t: read_data expected %h, got %h", $time, want.data,
							read_data);
						errors++;
					end
					if (audio_on !== want.audio) begin
						$display("%0t: audio_on expected %b, got %b", $time, want.audio,
							audio_on);
						errors++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		write_ntsc(1'b1);

		access_backlog.push_back(mk_access(KIND_READ, OFS_KEYS, 16'h0000, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_READ, OFS_FIRE, 16'hFFFF, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_KEYS, 16'h817E, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		access_backlog.push_back(mk_access(KIND_READ, OFS_KEYS, 16'h0000, 16'hFFFF, 5'h00,
			16'hFFFF, 5'h00));
		access_backlog.push_back(mk_access(KIND_READ, OFS_FIRE, 16'h0000, 16'h0000, 5'h1F,
			16'h0000, 5'h1F));
		access_backlog.push_back(mk_access(KIND_READ, OFS_KEYS, 16'h0000, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_ROW_HI, 16'hBD00, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_READ, OFS_KEYS, 16'hFFFF, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_READ, OFS_FIRE, 16'hFFFF, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_ROW_HI, 16'hDB00, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		access_backlog.push_back(mk_access(KIND_READ, OFS_KEYS, 16'h0000, 16'hA5C3, 5'h00,
			16'h3C5A, 5'h00));
		access_backlog.push_back(mk_access(KIND_READ, OFS_FIRE, 16'h0000, 16'h0000, 5'h0F,
			16'h0000, 5'h0F));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_ROW_HI, 16'hE700, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		access_backlog.push_back(mk_access(KIND_READ, OFS_KEYS, 16'h0000, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_READ, OFS_FIRE, 16'h0000, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_READ, OFS_ROW_HI, 16'h0000, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_READ, OFS_SPARE, 16'h0000, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_FIRE, 16'h0000, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_SPARE, 16'h0000, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_KEYS, 16'h8000, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		access_backlog.push_back(mk_access(KIND_READ, OFS_KEYS, 16'h0000, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_READ, OFS_FIRE, 16'h0000, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_KEYS, 16'hFFFF, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		access_backlog.push_back(mk_access(KIND_READ, OFS_KEYS, 16'h0000, 16'hFFFF, 5'h1F,
			16'hFFFF, 5'h1F));
		access_backlog.push_back(mk_access(KIND_WRITE, OFS_KEYS, 16'h0000, 16'h0000, 5'h00,
			16'h0000, 5'h00));
		settle();

		write_ntsc(1'b0);
		send_idle_pct = 25;
		recv_idle_pct = 57;
		repeat (400) access_backlog.push_back(random_access());
		settle();

		write_ntsc(1'b1);
		send_idle_pct = 57;
		recv_idle_pct = 25;
		repeat (400) access_backlog.push_back(random_access());
		settle();

		write_ntsc(1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (330) access_backlog.push_back(random_access());
		settle();

		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
